/* rtl/core/qpr_pkg.sv */
// ----------------------------------------------------------------------------
// qpr_pkg
// Shared constants and types for the 3x3 quadratic peak refinement block.
// ----------------------------------------------------------------------------
package qpr_pkg;

  // Defaults for the top-level parameters
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF   = 8;

  // Fixed field widths
  localparam int OFF_W  = 16;
  localparam int VAL_W  = 32;
  localparam int CFG_W  = 16;
  localparam int KIND_W = 2;

  // Extremum classification
  typedef enum logic [KIND_W-1:0] {
    KIND_NONE = 2'd0,
    KIND_MIN  = 2'd1,
    KIND_MAX  = 2'd2
  } kind_e;

endpackage

/* rtl/core/qpr_if.sv */
// ----------------------------------------------------------------------------
// qpr_if
// Valid/ready channels: 3x3 sample window in, refined peak out.
// ----------------------------------------------------------------------------
interface qpr_win_if #(
  parameter int SB = qpr_pkg::SAMPLE_BITS_DEF
);
  logic          valid;
  logic          ready;
  logic [SB-1:0] win_r0_c0;
  logic [SB-1:0] win_r0_c1;
  logic [SB-1:0] win_r0_c2;
  logic [SB-1:0] win_r1_c0;
  logic [SB-1:0] win_r1_c1;
  logic [SB-1:0] win_r1_c2;
  logic [SB-1:0] win_r2_c0;
  logic [SB-1:0] win_r2_c1;
  logic [SB-1:0] win_r2_c2;

  modport source (
    output valid, win_r0_c0, win_r0_c1, win_r0_c2, win_r1_c0, win_r1_c1,
           win_r1_c2, win_r2_c0, win_r2_c1, win_r2_c2,
    input  ready
  );
  modport sink (
    input  valid, win_r0_c0, win_r0_c1, win_r0_c2, win_r1_c0, win_r1_c1,
           win_r1_c2, win_r2_c0, win_r2_c1, win_r2_c2,
    output ready
  );
endinterface

interface qpr_res_if;
  logic                           valid;
  logic                           ready;
  logic [qpr_pkg::OFF_W-1:0]      offset_x;
  logic [qpr_pkg::OFF_W-1:0]      offset_y;
  logic [qpr_pkg::VAL_W-1:0]      peak_value;
  logic [qpr_pkg::KIND_W-1:0]     extremum_kind;

  modport source (
    output valid, offset_x, offset_y, peak_value, extremum_kind,
    input  ready
  );
  modport sink (
    input  valid, offset_x, offset_y, peak_value, extremum_kind,
    output ready
  );
endinterface

/* rtl/core/qpr_div.sv */
// ----------------------------------------------------------------------------
// qpr_div
// Pipelined restoring divider: round(num * 2^FRAC / den), ties away from
// zero, saturated to a signed OUT_W result. One quotient bit per stage.
// ----------------------------------------------------------------------------
module qpr_div #(
  parameter int WN    = 44,
  parameter int WD    = 44,
  parameter int FRAC  = qpr_pkg::FRAC_BITS_DEF,
  parameter int QB    = qpr_pkg::VAL_W,
  parameter int OUT_W = qpr_pkg::OFF_W,
  parameter int TAG_W = 1
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic signed [WN-1:0]    num_i,
  input  logic        [WD-1:0]    den_i,
  input  logic        [TAG_W-1:0] tag_i,
  output logic signed [OUT_W-1:0] res_o,
  output logic        [TAG_W-1:0] tag_o
);

  localparam int WD2 = WD + 1;
  localparam int WM  = WN + FRAC + 1;
  localparam int WN2 = ((WM > WD) ? WM : WD) + 1;
  localparam int WC  = (WN2 > WD2 + QB) ? WN2 : WD2 + QB;

  // Pipeline storage, index 0 is the set-up stage
  logic [WC-1:0]    rem_q [QB+1];
  logic [WD2-1:0]   d2_q  [QB+1];
  logic [QB-1:0]    quo_q [QB+1];
  logic             neg_q [QB+1];
  logic             ovf_q [QB+1];
  logic [TAG_W-1:0] tag_q [QB+2];

  // Set-up: magnitude, doubled and offset for rounding
  logic          neg_d;
  logic [WN-1:0] mag_d;
  logic [WC-1:0] n2_d;
  logic [WD2-1:0] d2_d;
  logic          ovf_d;

  assign neg_d = num_i[WN-1];
  assign mag_d = neg_d ? WN'(-num_i) : WN'(num_i);
  assign n2_d  = (WC'(mag_d) << (FRAC + 1)) + WC'(den_i);
  assign d2_d  = {den_i, 1'b0};
  assign ovf_d = n2_d >= (WC'(d2_d) << QB);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= n2_d;
      d2_q[0]  <= d2_d;
      quo_q[0] <= '0;
      neg_q[0] <= neg_d;
      ovf_q[0] <= ovf_d;
    end
  end

  // One quotient bit per stage, most significant first
  for (genvar j = 1; j <= QB; j++) begin : g_stage
    logic [WC-1:0] sh;
    logic          ge;
    assign sh = WC'(d2_q[j-1]) << (QB - j);
    assign ge = rem_q[j-1] >= sh;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j] <= ge ? rem_q[j-1] - sh : rem_q[j-1];
        d2_q[j]  <= d2_q[j-1];
        quo_q[j] <= {quo_q[j-1][QB-2:0], ge};
        neg_q[j] <= neg_q[j-1];
        ovf_q[j] <= ovf_q[j-1];
      end
    end
  end

  // Sign and saturation
  logic [QB-1:0]    lim;
  logic             sat;
  logic [OUT_W-1:0] qt;
  logic signed [OUT_W-1:0] res_d;
  logic signed [OUT_W-1:0] res_q;

  assign lim = neg_q[QB] ? (QB'(1) << (OUT_W - 1)) : (QB'(1) << (OUT_W - 1)) - QB'(1);
  assign sat = ovf_q[QB] || (quo_q[QB] > lim);
  assign qt  = quo_q[QB][OUT_W-1:0];

  always_comb begin
    if (sat) begin
      res_d = neg_q[QB] ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}};
    end else begin
      res_d = neg_q[QB] ? $signed(-qt) : $signed(qt);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q <= res_d;
    end
  end

  // Tag travels alongside, cleared by reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < QB + 2; k++) begin
        tag_q[k] <= '0;
      end
    end else if (en_i) begin
      tag_q[0] <= tag_i;
      for (int k = 1; k < QB + 2; k++) begin
        tag_q[k] <= tag_q[k-1];
      end
    end
  end

  assign res_o = res_q;
  assign tag_o = tag_q[QB+1];

endmodule

/* rtl/core/quadratic_peak_refine_3x3.sv */
// ----------------------------------------------------------------------------
// quadratic_peak_refine_3x3
// Sub-sample extremum of a 3x3 window by exact least-squares quadratic fit.
// ----------------------------------------------------------------------------
// Takes one window per clock while the output is not stalled and returns one
// result per window, in order. Six stages of fit, determinant and wide
// products feed a restoring divider that resolves one quotient bit per
// stage. Throughput is one transaction per cycle; a stall at the output
// freezes the whole pipeline. min_det may only be written while no
// transaction is in flight.
module quadratic_peak_refine_3x3 #(
  parameter int SAMPLE_BITS = qpr_pkg::SAMPLE_BITS_DEF,
  parameter int FRAC_BITS   = qpr_pkg::FRAC_BITS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [qpr_pkg::CFG_W-1:0] cfg_wdata_i,
  qpr_win_if.sink                   win_i,
  qpr_res_if.source                 res_o
);

  localparam int S    = SAMPLE_BITS;
  localparam int WK   = S + 2;
  localparam int WA   = S + 4;
  localparam int WB   = S + 2;
  localparam int WDE  = S + 3;
  localparam int WF   = S + 5;
  localparam int WDN  = 2 * S + 12;
  localparam int WNX  = 2 * S + 10;
  localparam int WV   = 3 * S + 19;
  localparam int WDV  = WDN + 6;
  localparam int WT   = 2 * S + 16;
  localparam int WF4  = WF + 2;
  localparam int WD3  = WDE + 2;
  localparam int HD   = WDN / 2;
  localparam int HN   = WNX / 2;

  // Configuration register
  logic [qpr_pkg::CFG_W-1:0] min_det_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_det_q <= '0;
    end else if (cfg_we_i) begin
      min_det_q <= cfg_wdata_i;
    end
  end

  // Pipeline advance
  logic en;
  assign en = !res_o.valid || res_o.ready;
  assign win_i.ready = en;

  // Valid bits of the front stages
  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      {v1_q, v2_q, v3_q, v4_q, v5_q, v6_q} <= '0;
    end else if (en) begin
      v1_q <= win_i.valid;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
      v6_q <= v5_q;
    end
  end

  // Stage 1: fit coefficients over common denominators
  logic signed [S-1:0] w00, w01, w02, w10, w11, w12, w20, w21, w22;
  assign w00 = $signed(win_i.win_r0_c0);
  assign w01 = $signed(win_i.win_r0_c1);
  assign w02 = $signed(win_i.win_r0_c2);
  assign w10 = $signed(win_i.win_r1_c0);
  assign w11 = $signed(win_i.win_r1_c1);
  assign w12 = $signed(win_i.win_r1_c2);
  assign w20 = $signed(win_i.win_r2_c0);
  assign w21 = $signed(win_i.win_r2_c1);
  assign w22 = $signed(win_i.win_r2_c2);

  logic signed [WK-1:0] k0, k1, k2, r0, r1, r2;
  assign k0 = WK'(w00) + WK'(w10) + WK'(w20);
  assign k1 = WK'(w01) + WK'(w11) + WK'(w21);
  assign k2 = WK'(w02) + WK'(w12) + WK'(w22);
  assign r0 = WK'(w00) + WK'(w01) + WK'(w02);
  assign r1 = WK'(w10) + WK'(w11) + WK'(w12);
  assign r2 = WK'(w20) + WK'(w21) + WK'(w22);

  logic signed [WA-1:0]  a_d, c_d, a_q, c_q;
  logic signed [WB-1:0]  b_d, b_q;
  logic signed [WDE-1:0] d_d, e_d, d_q, e_q;
  logic signed [WF-1:0]  f_d, f_q;
  assign a_d = WA'(k0) - (WA'(k1) <<< 1) + WA'(k2);
  assign c_d = WA'(r0) - (WA'(r1) <<< 1) + WA'(r2);
  assign b_d = WB'(w00) - WB'(w02) - WB'(w20) + WB'(w22);
  assign d_d = WDE'(k2) - WDE'(k0);
  assign e_d = WDE'(r2) - WDE'(r0);
  assign f_d = ((WF'(w01) + WF'(w10) + WF'(w12) + WF'(w21)) <<< 1)
             + (WF'(w11) <<< 2) + WF'(w11)
             - (WF'(w00) + WF'(w02) + WF'(w20) + WF'(w22));

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_q <= a_d;
      b_q <= b_d;
      c_q <= c_d;
      d_q <= d_d;
      e_q <= e_d;
      f_q <= f_d;
    end
  end

  // Stage 2: pairwise products
  logic signed [2*WA-1:0]   ac_q;
  logic signed [2*WB-1:0]   bb_q;
  logic signed [WB+WDE-1:0] be_q, bd_q;
  logic signed [WA+WDE-1:0] cd_q, ae_q;
  logic signed [WDE-1:0]    d2_q, e2_q;
  logic signed [WF-1:0]     f2_q;
  logic                     apos2_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      ac_q    <= a_q * c_q;
      bb_q    <= b_q * b_q;
      be_q    <= b_q * e_q;
      bd_q    <= b_q * d_q;
      cd_q    <= c_q * d_q;
      ae_q    <= a_q * e_q;
      d2_q    <= d_q;
      e2_q    <= e_q;
      f2_q    <= f_q;
      apos2_q <= a_q > 0;
    end
  end

  // Stage 3: determinant and offset numerators
  logic signed [WDN-1:0] dn_d, dn_q;
  logic signed [WNX-1:0] nx_d, ny_d, nx_q, ny_q;
  logic signed [WDE-1:0] d3_q, e3_q;
  logic signed [WF-1:0]  f3_q;
  logic                  apos3_q;
  assign dn_d = (WDN'(ac_q) <<< 4) - (WDN'(bb_q) <<< 3) - WDN'(bb_q);
  assign nx_d = (WNX'(be_q) <<< 2) + (WNX'(be_q) <<< 1) - (WNX'(cd_q) <<< 3);
  assign ny_d = (WNX'(bd_q) <<< 2) + (WNX'(bd_q) <<< 1) - (WNX'(ae_q) <<< 3);
  always_ff @(posedge clk_i) begin
    if (en) begin
      dn_q    <= dn_d;
      nx_q    <= nx_d;
      ny_q    <= ny_d;
      d3_q    <= d2_q;
      e3_q    <= e2_q;
      f3_q    <= f2_q;
      apos3_q <= apos2_q;
    end
  end

  // Stage 4: threshold test and split partial products of the value numerator
  logic signed [WT-1:0]  thr_l, thr_r;
  logic                  flat_d;
  qpr_pkg::kind_e        kind_d;
  logic signed [WF4-1:0] f4x;
  logic signed [WD3-1:0] d3x, e3x;
  assign thr_l  = WT'(dn_q) <<< 4;
  assign thr_r  = $signed((WT'(min_det_q) << 3) + WT'(min_det_q));
  assign flat_d = thr_l <= thr_r;
  assign kind_d = flat_d ? qpr_pkg::KIND_NONE
                         : (apos3_q ? qpr_pkg::KIND_MIN : qpr_pkg::KIND_MAX);
  assign f4x    = WF4'(f3_q) <<< 2;
  assign d3x    = (WD3'(d3_q) <<< 1) + WD3'(d3_q);
  assign e3x    = (WD3'(e3_q) <<< 1) + WD3'(e3_q);

  logic signed [WF4+HD:0]          pf_lo_q;
  logic signed [WF4+WDN-HD-1:0]    pf_hi_q;
  logic signed [WD3+HN:0]          px_lo_q, py_lo_q;
  logic signed [WD3+WNX-HN-1:0]    px_hi_q, py_hi_q;
  logic signed [WDN-1:0]           dn4_q;
  logic signed [WNX-1:0]           nx4_q, ny4_q;
  logic signed [WF-1:0]            f4_q;
  logic                            flat4_q;
  qpr_pkg::kind_e                  kind4_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      pf_lo_q <= f4x * $signed({1'b0, dn_q[HD-1:0]});
      pf_hi_q <= f4x * $signed(dn_q[WDN-1:HD]);
      px_lo_q <= d3x * $signed({1'b0, nx_q[HN-1:0]});
      px_hi_q <= d3x * $signed(nx_q[WNX-1:HN]);
      py_lo_q <= e3x * $signed({1'b0, ny_q[HN-1:0]});
      py_hi_q <= e3x * $signed(ny_q[WNX-1:HN]);
      dn4_q   <= dn_q;
      nx4_q   <= nx_q;
      ny4_q   <= ny_q;
      f4_q    <= f3_q;
      flat4_q <= flat_d;
      kind4_q <= kind_d;
    end
  end

  // Stage 5: recombine partial products, scale the value denominator
  logic signed [WV-1:0]  tf_q, tx_q, ty_q;
  logic signed [WDV-1:0] den36_q;
  logic signed [WDN-1:0] dn5_q;
  logic signed [WNX-1:0] nx5_q, ny5_q;
  logic signed [WF-1:0]  f5_q;
  logic                  flat5_q;
  qpr_pkg::kind_e        kind5_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      tf_q    <= (WV'(pf_hi_q) <<< HD) + WV'(pf_lo_q);
      tx_q    <= (WV'(px_hi_q) <<< HN) + WV'(px_lo_q);
      ty_q    <= (WV'(py_hi_q) <<< HN) + WV'(py_lo_q);
      den36_q <= (WDV'(dn4_q) <<< 5) + (WDV'(dn4_q) <<< 2);
      dn5_q   <= dn4_q;
      nx5_q   <= nx4_q;
      ny5_q   <= ny4_q;
      f5_q    <= f4_q;
      flat5_q <= flat4_q;
      kind5_q <= kind4_q;
    end
  end

  // Stage 6: value numerator; flat windows divide the constant term by nine
  logic signed [WV-1:0]  vnum_q;
  logic [WDV-1:0]        vden_q;
  logic [WDN-1:0]        oden_q;
  logic signed [WNX-1:0] nx6_q, ny6_q;
  logic                  flat6_q;
  qpr_pkg::kind_e        kind6_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      vnum_q  <= flat5_q ? WV'(f5_q) : tf_q + tx_q + ty_q;
      vden_q  <= flat5_q ? WDV'(9) : WDV'(den36_q);
      oden_q  <= WDN'(dn5_q);
      nx6_q   <= nx5_q;
      ny6_q   <= ny5_q;
      flat6_q <= flat5_q;
      kind6_q <= kind5_q;
    end
  end

  // Dividers, all of equal latency
  logic signed [qpr_pkg::OFF_W-1:0] ox_res, oy_res;
  logic signed [qpr_pkg::VAL_W-1:0] val_res;
  logic                             ox_flat, oy_flat;
  logic [qpr_pkg::KIND_W:0]         vtag;

  qpr_div #(
    .WN(WNX), .WD(WDN), .FRAC(FRAC_BITS), .QB(qpr_pkg::VAL_W),
    .OUT_W(qpr_pkg::OFF_W), .TAG_W(1)
  ) u_div_x (
    .clk_i, .rst_ni, .en_i(en), .num_i(nx6_q), .den_i(oden_q),
    .tag_i(flat6_q), .res_o(ox_res), .tag_o(ox_flat)
  );

  qpr_div #(
    .WN(WNX), .WD(WDN), .FRAC(FRAC_BITS), .QB(qpr_pkg::VAL_W),
    .OUT_W(qpr_pkg::OFF_W), .TAG_W(1)
  ) u_div_y (
    .clk_i, .rst_ni, .en_i(en), .num_i(ny6_q), .den_i(oden_q),
    .tag_i(flat6_q), .res_o(oy_res), .tag_o(oy_flat)
  );

  qpr_div #(
    .WN(WV), .WD(WDV), .FRAC(FRAC_BITS), .QB(qpr_pkg::VAL_W),
    .OUT_W(qpr_pkg::VAL_W), .TAG_W(qpr_pkg::KIND_W + 1)
  ) u_div_v (
    .clk_i, .rst_ni, .en_i(en), .num_i(vnum_q), .den_i(vden_q),
    .tag_i({v6_q, kind6_q}), .res_o(val_res), .tag_o(vtag)
  );

  // Output transaction
  assign res_o.valid         = vtag[qpr_pkg::KIND_W];
  assign res_o.extremum_kind = vtag[qpr_pkg::KIND_W-1:0];
  assign res_o.offset_x      = ox_flat ? '0 : ox_res;
  assign res_o.offset_y      = oy_flat ? '0 : oy_res;
  assign res_o.peak_value    = val_res;

`ifndef SYNTHESIS
  // A window with no extremum must leave the offset dividers flagged flat
  a_none_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && (res_o.extremum_kind == qpr_pkg::KIND_NONE)
      |-> (ox_flat && oy_flat))
    else $error("offset flag out of step with kind");

  // A flat flag on the x offset divider agrees with the kind
  a_flat_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && ox_flat |-> (res_o.extremum_kind == qpr_pkg::KIND_NONE))
    else $error("flat window reported as extremum");

  // A stall freezes the front of the pipeline
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(v6_q) && $stable(v1_q))
    else $error("pipeline moved during stall");
`endif

endmodule
